### design/mpk_pkg.sv
// Shared types and constants for the MessagePack token parser.
// Used by msgpack_token_parser_core and by its port checker; no dependencies.
`timescale 1ns / 1ps
`default_nettype none

package mpk_pkg;

    typedef enum logic [3:0] {
        TK_NIL      = 4'd0,
        TK_FALSE    = 4'd1,
        TK_TRUE     = 4'd2,
        TK_UINT     = 4'd3,
        TK_SINT     = 4'd4,
        TK_F32      = 4'd5,
        TK_F64      = 4'd6,
        TK_STR      = 4'd7,
        TK_BIN      = 4'd8,
        TK_ARRAY    = 4'd9,
        TK_MAP      = 4'd10,
        TK_PAYLOAD  = 4'd11,
        TK_RESERVED = 4'd12,
        TK_EXT      = 4'd13,
        TK_TRUNC    = 4'd14
    } token_kind_t;

    localparam int KIND_W     = 4;
    localparam int VALUE_W    = 64;
    localparam int LEN_W      = 32;
    localparam int M_TDATA_W  = 72;
    localparam int M_PAD_W    = M_TDATA_W - KIND_W - VALUE_W;

    localparam logic [7:0]         FIXMAP_MASK  = 8'h0f;
    localparam logic [7:0]         FIXSTR_MASK  = 8'h1f;
    localparam logic [7:0]         NIL_MARKER   = 8'hc0;
    localparam logic [7:0]         NEG_FIX_MIN  = 8'he0;
    localparam logic [VALUE_W-1:0] NEG_FIX_BASE = 64'hffff_ffff_ffff_ffe0;

endpackage : mpk_pkg

`default_nettype wire

### design/msgpack_token_parser_core.sv
// MessagePack byte-stream tokenizer: marker decode, field assembly, payload pass-through.
// Depends on mpk_pkg for the token kind type and marker constants.
`timescale 1ns / 1ps
`default_nettype none

// Usage:
// The s_ channel carries one encoded byte per item in s_tdata, with s_tlast set on
// the final byte of a message. The m_ channel carries one token per item: m_tdata
// holds the token kind in bits 3:0 and the 64-bit value in bits 67:4, and m_tlast
// marks the last payload byte of a str or bin. Bytes that only feed a multi-byte
// field give no token.
// Throughput is one byte per clock while s_tready is high. The parse state and the
// token for a byte are worked out in one combinational pass from the state registers,
// and the token is registered in the output register, or in the skid one if it stalls.
// The output side has an output register and one skid register, and s_tready comes
// from the skid register alone. When the receiver stalls, up to two tokens are held;
// s_tready then drops until the stall clears, and nothing is lost or reordered.
// A message that ends inside an item gives a truncated token, and every byte marked
// with s_tlast returns the parser to its idle state.
// Reset (aresetn low, synchronous) empties both output registers and puts the parser
// back to waiting for a marker byte.
module msgpack_token_parser_core
    import mpk_pkg::*;
(
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 s_tvalid,
    output logic                      s_tready,
    input  wire logic [7:0]           s_tdata,   // byte_in
    input  wire logic                 s_tlast,   // message_end
    output logic                      m_tvalid,
    input  wire logic                 m_tready,
    output logic [M_TDATA_W-1:0]      m_tdata,   // token_kind[3:0], token_value[67:4], zeros
    output logic                      m_tlast    // payload_last
);

    typedef enum logic [1:0] {
        PH_IDLE,
        PH_FIELD,
        PH_PAYLOAD,
        PH_SFIRST
    } phase_t;

    phase_t             phase_reg,        phase_next;
    token_kind_t        pend_kind_reg,    pend_kind_next;
    logic [3:0]         field_left_reg,   field_left_next;
    logic [VALUE_W-1:0] acc_reg,          acc_next;
    logic [LEN_W-1:0]   payload_left_reg, payload_left_next;

    logic               out_valid_reg;
    token_kind_t        out_kind_reg;
    logic [VALUE_W-1:0] out_value_reg;
    logic               out_last_reg;
    logic               skid_valid_reg;
    token_kind_t        skid_kind_reg;
    logic [VALUE_W-1:0] skid_value_reg;
    logic               skid_last_reg;

    logic               accept;
    logic               tok_valid;
    token_kind_t        tok_kind;
    logic [VALUE_W-1:0] tok_value;
    logic               tok_last;

    logic               do_hdr;
    token_kind_t        hdr_kind;
    logic [LEN_W-1:0]   hdr_len;
    logic               do_start;
    token_kind_t        start_kind;
    logic [3:0]         start_bytes;
    logic [VALUE_W-1:0] acc_base;
    logic [VALUE_W-1:0] acc_shift;
    logic [3:0]         field_dec;

    assign s_tready = !skid_valid_reg;
    assign accept   = s_tvalid && s_tready;

    always_comb begin
        phase_next        = PH_IDLE;
        pend_kind_next    = TK_NIL;
        field_left_next   = '0;
        acc_next          = '0;
        payload_left_next = '0;
        tok_valid         = 1'b0;
        tok_kind          = TK_NIL;
        tok_value         = '0;
        tok_last          = 1'b0;
        do_hdr            = 1'b0;
        hdr_kind          = TK_STR;
        hdr_len           = '0;
        do_start          = 1'b0;
        start_kind        = TK_UINT;
        start_bytes       = '0;

        acc_base  = (phase_reg == PH_SFIRST) ? {VALUE_W{s_tdata[7]}} : acc_reg;
        acc_shift = {acc_base[VALUE_W-9:0], s_tdata};
        field_dec = (field_left_reg != 4'd0) ? field_left_reg - 4'd1 : 4'd0;

        if (!accept) begin
            phase_next        = phase_reg;
            pend_kind_next    = pend_kind_reg;
            field_left_next   = field_left_reg;
            acc_next          = acc_reg;
            payload_left_next = payload_left_reg;
        end else begin
            case (phase_reg)
                PH_PAYLOAD: begin
                    if (payload_left_reg <= 32'd1) begin
                        tok_valid = 1'b1;
                        tok_kind  = TK_PAYLOAD;
                        tok_value = {56'd0, s_tdata};
                        tok_last  = 1'b1;
                    end else if (s_tlast) begin
                        tok_valid = 1'b1;
                        tok_kind  = TK_TRUNC;
                    end else begin
                        phase_next        = PH_PAYLOAD;
                        payload_left_next = payload_left_reg - 32'd1;
                        tok_valid         = 1'b1;
                        tok_kind          = TK_PAYLOAD;
                        tok_value         = {56'd0, s_tdata};
                    end
                end
                PH_FIELD, PH_SFIRST: begin
                    if (field_dec != 4'd0) begin
                        if (s_tlast) begin
                            tok_valid = 1'b1;
                            tok_kind  = TK_TRUNC;
                        end else begin
                            phase_next      = PH_FIELD;
                            pend_kind_next  = pend_kind_reg;
                            field_left_next = field_dec;
                            acc_next        = acc_shift;
                        end
                    end else if (pend_kind_reg == TK_STR || pend_kind_reg == TK_BIN) begin
                        do_hdr   = 1'b1;
                        hdr_kind = pend_kind_reg;
                        hdr_len  = acc_shift[LEN_W-1:0];
                    end else begin
                        tok_valid = 1'b1;
                        tok_kind  = pend_kind_reg;
                        tok_value = acc_shift;
                    end
                end
                default: begin
                    tok_valid = 1'b1;
                    case (s_tdata) inside
                        [8'h00:8'h7f]: begin
                            tok_kind  = TK_UINT;
                            tok_value = {56'd0, s_tdata};
                        end
                        [NEG_FIX_MIN:8'hff]: begin
                            tok_kind  = TK_SINT;
                            tok_value = NEG_FIX_BASE | {56'd0, s_tdata & FIXSTR_MASK};
                        end
                        [8'h80:8'h8f]: begin
                            tok_kind  = TK_MAP;
                            tok_value = {56'd0, s_tdata & FIXMAP_MASK};
                        end
                        [8'h90:8'h9f]: begin
                            tok_kind  = TK_ARRAY;
                            tok_value = {56'd0, s_tdata & FIXMAP_MASK};
                        end
                        [8'ha0:8'hbf]: begin
                            tok_valid = 1'b0;
                            do_hdr    = 1'b1;
                            hdr_kind  = TK_STR;
                            hdr_len   = {24'd0, s_tdata & FIXSTR_MASK};
                        end
                        NIL_MARKER: tok_kind = TK_NIL;
                        8'hc2:      tok_kind = TK_FALSE;
                        8'hc3:      tok_kind = TK_TRUE;
                        8'hc1: begin
                            tok_kind  = TK_RESERVED;
                            tok_value = {56'd0, s_tdata};
                        end
                        8'hc4, 8'hc5, 8'hc6, 8'hca, 8'hcb, 8'hcc, 8'hcd, 8'hce, 8'hcf,
                        8'hd0, 8'hd1, 8'hd2, 8'hd3, 8'hd9, 8'hda, 8'hdb,
                        8'hdc, 8'hdd, 8'hde, 8'hdf: begin
                            tok_valid = 1'b0;
                            do_start  = 1'b1;
                        end
                        default: begin
                            tok_kind  = TK_EXT;
                            tok_value = {56'd0, s_tdata};
                        end
                    endcase

                    // Kind and size of the fixed field that follows a marker.
                    case (s_tdata)
                        8'hc4: begin start_kind = TK_BIN;   start_bytes = 4'd1; end
                        8'hc5: begin start_kind = TK_BIN;   start_bytes = 4'd2; end
                        8'hc6: begin start_kind = TK_BIN;   start_bytes = 4'd4; end
                        8'hca: begin start_kind = TK_F32;   start_bytes = 4'd4; end
                        8'hcb: begin start_kind = TK_F64;   start_bytes = 4'd8; end
                        8'hcc: begin start_kind = TK_UINT;  start_bytes = 4'd1; end
                        8'hcd: begin start_kind = TK_UINT;  start_bytes = 4'd2; end
                        8'hce: begin start_kind = TK_UINT;  start_bytes = 4'd4; end
                        8'hcf: begin start_kind = TK_UINT;  start_bytes = 4'd8; end
                        8'hd0: begin start_kind = TK_SINT;  start_bytes = 4'd1; end
                        8'hd1: begin start_kind = TK_SINT;  start_bytes = 4'd2; end
                        8'hd2: begin start_kind = TK_SINT;  start_bytes = 4'd4; end
                        8'hd3: begin start_kind = TK_SINT;  start_bytes = 4'd8; end
                        8'hd9: begin start_kind = TK_STR;   start_bytes = 4'd1; end
                        8'hda: begin start_kind = TK_STR;   start_bytes = 4'd2; end
                        8'hdb: begin start_kind = TK_STR;   start_bytes = 4'd4; end
                        8'hdc: begin start_kind = TK_ARRAY; start_bytes = 4'd2; end
                        8'hdd: begin start_kind = TK_ARRAY; start_bytes = 4'd4; end
                        8'hde: begin start_kind = TK_MAP;   start_bytes = 4'd2; end
                        8'hdf: begin start_kind = TK_MAP;   start_bytes = 4'd4; end
                        default: begin start_kind = TK_UINT; start_bytes = 4'd0; end
                    endcase
                end
            endcase

            // A str or bin length is known: enter the payload unless it is empty or the message ends here.
            if (do_hdr) begin
                tok_valid = 1'b1;
                if (hdr_len != '0 && s_tlast) begin
                    tok_kind = TK_TRUNC;
                end else begin
                    tok_kind  = hdr_kind;
                    tok_value = {{(VALUE_W-LEN_W){1'b0}}, hdr_len};
                    if (hdr_len != '0) begin
                        phase_next        = PH_PAYLOAD;
                        payload_left_next = hdr_len;
                    end
                end
            end

            if (do_start) begin
                if (s_tlast) begin
                    tok_valid = 1'b1;
                    tok_kind  = TK_TRUNC;
                end else begin
                    phase_next      = (start_kind == TK_SINT) ? PH_SFIRST : PH_FIELD;
                    pend_kind_next  = start_kind;
                    field_left_next = start_bytes;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg        <= PH_IDLE;
            pend_kind_reg    <= TK_NIL;
            field_left_reg   <= '0;
            acc_reg          <= '0;
            payload_left_reg <= '0;
            out_valid_reg    <= 1'b0;
            skid_valid_reg   <= 1'b0;
        end else begin
            phase_reg        <= phase_next;
            pend_kind_reg    <= pend_kind_next;
            field_left_reg   <= field_left_next;
            acc_reg          <= acc_next;
            payload_left_reg <= payload_left_next;

            if (m_tready || !out_valid_reg) begin
                if (skid_valid_reg) begin
                    out_valid_reg  <= 1'b1;
                    out_kind_reg   <= skid_kind_reg;
                    out_value_reg  <= skid_value_reg;
                    out_last_reg   <= skid_last_reg;
                    skid_valid_reg <= 1'b0;
                end else begin
                    out_valid_reg <= tok_valid;
                    out_kind_reg  <= tok_kind;
                    out_value_reg <= tok_value;
                    out_last_reg  <= tok_last;
                end
            end else if (tok_valid) begin
                // The output register is stalled; park the new token.
                skid_valid_reg <= 1'b1;
                skid_kind_reg  <= tok_kind;
                skid_value_reg <= tok_value;
                skid_last_reg  <= tok_last;
            end
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{M_PAD_W{1'b0}}, out_value_reg, out_kind_reg};
    assign m_tlast  = out_last_reg;

endmodule : msgpack_token_parser_core

`default_nettype wire

### design/mpk_checker.sv
// Port-level checks for msgpack_token_parser_core, attached by the bind at the end.
// Depends on mpk_pkg for the token kinds and the result bus layout.
`timescale 1ns / 1ps
`default_nettype none

module mpk_checker
    import mpk_pkg::*;
(
    input wire logic                 aclk,
    input wire logic                 aresetn,
    input wire logic                 m_tvalid,
    input wire logic                 m_tready,
    input wire logic [M_TDATA_W-1:0] m_tdata,   // token_kind[3:0], token_value[67:4], zeros
    input wire logic                 m_tlast    // payload_last
);

    logic [KIND_W-1:0]  kind;
    logic [VALUE_W-1:0] value;

    assign kind  = m_tdata[KIND_W-1:0];
    assign value = m_tdata[KIND_W+VALUE_W-1:KIND_W];

    // A stalled item stays on the bus unchanged.
    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("result item changed while stalled");

    // The last-byte flag only appears on a payload byte.
    a_last_payload: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tlast |-> kind == TK_PAYLOAD && value[VALUE_W-1:8] == '0)
        else $error("payload_last on a token that is not a payload byte");

    // Tokens without a value carry zero.
    a_zero_value: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (kind == TK_NIL || kind == TK_FALSE || kind == TK_TRUE ||
                     kind == TK_TRUNC) |-> value == '0 && !m_tlast)
        else $error("valueless token with nonzero value or last flag");

    // Array and map counts and str/bin lengths fit in 32 bits.
    a_header_len: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (kind == TK_STR || kind == TK_BIN || kind == TK_ARRAY ||
                     kind == TK_MAP) |-> value[VALUE_W-1:LEN_W] == '0)
        else $error("header length wider than 32 bits");

    a_pad_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[M_TDATA_W-1:KIND_W+VALUE_W] == '0)
        else $error("padding bits of the result bus are not zero");

endmodule : mpk_checker

bind msgpack_token_parser_core mpk_checker u_mpk_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
);

`default_nettype wire

### tb/mpk_marker_pkg.sv
// MessagePack marker byte values shared by the token checker and the testbench top.
// Depends on nothing; the nil and negative fixint bounds come from mpk_pkg.
`timescale 1ns / 1ps

package mpk_marker_pkg;

    localparam logic [7:0] MK_POSFIX_MAX   = 8'h7f;
    localparam logic [7:0] MK_FIXMAP       = 8'h80;
    localparam logic [7:0] MK_FIXMAP_MAX   = 8'h8f;
    localparam logic [7:0] MK_FIXARRAY     = 8'h90;
    localparam logic [7:0] MK_FIXARRAY_MAX = 8'h9f;
    localparam logic [7:0] MK_FIXSTR       = 8'ha0;
    localparam logic [7:0] MK_FIXSTR_MAX   = 8'hbf;
    localparam logic [7:0] MK_RESERVED     = 8'hc1;
    localparam logic [7:0] MK_FALSE        = 8'hc2;
    localparam logic [7:0] MK_TRUE         = 8'hc3;
    localparam logic [7:0] MK_BIN8         = 8'hc4;
    localparam logic [7:0] MK_BIN16        = 8'hc5;
    localparam logic [7:0] MK_BIN32        = 8'hc6;
    localparam logic [7:0] MK_EXT8         = 8'hc7;
    localparam logic [7:0] MK_EXT16        = 8'hc8;
    localparam logic [7:0] MK_EXT32        = 8'hc9;
    localparam logic [7:0] MK_FLOAT32      = 8'hca;
    localparam logic [7:0] MK_FLOAT64      = 8'hcb;
    localparam logic [7:0] MK_UINT8        = 8'hcc;
    localparam logic [7:0] MK_UINT16       = 8'hcd;
    localparam logic [7:0] MK_UINT32       = 8'hce;
    localparam logic [7:0] MK_UINT64       = 8'hcf;
    localparam logic [7:0] MK_INT8         = 8'hd0;
    localparam logic [7:0] MK_INT16        = 8'hd1;
    localparam logic [7:0] MK_INT32        = 8'hd2;
    localparam logic [7:0] MK_INT64        = 8'hd3;
    localparam logic [7:0] MK_FIXEXT1      = 8'hd4;
    localparam logic [7:0] MK_FIXEXT2      = 8'hd5;
    localparam logic [7:0] MK_FIXEXT4      = 8'hd6;
    localparam logic [7:0] MK_FIXEXT8      = 8'hd7;
    localparam logic [7:0] MK_FIXEXT16     = 8'hd8;
    localparam logic [7:0] MK_STR8         = 8'hd9;
    localparam logic [7:0] MK_STR16        = 8'hda;
    localparam logic [7:0] MK_STR32        = 8'hdb;
    localparam logic [7:0] MK_ARRAY16      = 8'hdc;
    localparam logic [7:0] MK_ARRAY32      = 8'hdd;
    localparam logic [7:0] MK_MAP16        = 8'hde;
    localparam logic [7:0] MK_MAP32        = 8'hdf;

endpackage : mpk_marker_pkg

### tb/mpk_token_checker.sv
// Token checker for msgpack_token_parser_core: decodes every accepted byte on its own
// and compares each emitted token with the oldest one it predicted.
// Depends on mpk_pkg for the token kinds and widths and on mpk_marker_pkg for markers.
`timescale 1ns / 1ps

module mpk_token_checker
    import mpk_pkg::*;
    import mpk_marker_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    input  logic                 s_tready,
    input  logic [7:0]           s_tdata,   // byte_in
    input  logic                 s_tlast,   // message_end
    input  logic                 m_tvalid,
    input  logic                 m_tready,
    input  logic [M_TDATA_W-1:0] m_tdata,   // token_kind[3:0], token_value[67:4], zeros
    input  logic                 m_tlast,   // payload_last
    output int                   fail_count,
    output int                   tokens_pending
);

    typedef enum logic [1:0] {
        PS_MARKER,
        PS_FIELD,
        PS_PAYLOAD,
        PS_SIGN_BYTE
    } parse_state_t;

    typedef struct {
        token_kind_t        kind;
        logic [VALUE_W-1:0] value;
        logic               last;
    } token_t;

    token_t             tokens_due[$];
    parse_state_t       parse_state;
    token_kind_t        field_kind;
    logic [3:0]         owed_field_bytes;
    logic [VALUE_W-1:0] field_acc;
    logic [LEN_W-1:0]   owed_payload_bytes;
    int                 fails = 0;

    task automatic push_token(input token_kind_t kind, input logic [VALUE_W-1:0] value,
                              input logic last);
        token_t t;
        t.kind  = kind;
        t.value = value;
        t.last  = last;
        tokens_due.push_back(t);
    endtask

    task automatic clear_parse();
        parse_state        = PS_MARKER;
        field_kind         = TK_NIL;
        owed_field_bytes   = '0;
        field_acc          = '0;
        owed_payload_bytes = '0;
    endtask

    task automatic truncate();
        clear_parse();
        push_token(TK_TRUNC, '0, 1'b0);
    endtask

    // A str or bin header with a non-empty payload still owes its payload bytes.
    task automatic str_bin_header(input token_kind_t kind, input logic [LEN_W-1:0] len,
                                  input logic end_in);
        if (len != 0 && end_in) begin
            truncate();
        end else begin
            clear_parse();
            if (len != 0) begin
                parse_state        = PS_PAYLOAD;
                owed_payload_bytes = len;
            end
            push_token(kind, VALUE_W'(len), 1'b0);
        end
    endtask

    task automatic start_field(input token_kind_t kind, input int nbytes, input logic end_in);
        if (end_in) begin
            truncate();
        end else begin
            parse_state      = (kind == TK_SINT) ? PS_SIGN_BYTE : PS_FIELD;
            field_kind       = kind;
            owed_field_bytes = 4'(nbytes);
            field_acc        = '0;
        end
    endtask

    task automatic decode_marker(input logic [7:0] b, input logic end_in);
        if (b <= MK_POSFIX_MAX) begin
            push_token(TK_UINT, VALUE_W'(b), 1'b0);
        end else if (b >= NEG_FIX_MIN) begin
            push_token(TK_SINT, NEG_FIX_BASE | VALUE_W'(b & FIXSTR_MASK), 1'b0);
        end else if (b <= MK_FIXMAP_MAX) begin
            push_token(TK_MAP, VALUE_W'(b & FIXMAP_MASK), 1'b0);
        end else if (b <= MK_FIXARRAY_MAX) begin
            push_token(TK_ARRAY, VALUE_W'(b & FIXMAP_MASK), 1'b0);
        end else if (b <= MK_FIXSTR_MAX) begin
            str_bin_header(TK_STR, LEN_W'(b & FIXSTR_MASK), end_in);
        end else begin
            case (b)
                NIL_MARKER:  push_token(TK_NIL, '0, 1'b0);
                MK_FALSE:    push_token(TK_FALSE, '0, 1'b0);
                MK_TRUE:     push_token(TK_TRUE, '0, 1'b0);
                MK_RESERVED: push_token(TK_RESERVED, VALUE_W'(b), 1'b0);
                MK_BIN8:     start_field(TK_BIN, 1, end_in);
                MK_BIN16:    start_field(TK_BIN, 2, end_in);
                MK_BIN32:    start_field(TK_BIN, 4, end_in);
                MK_FLOAT32:  start_field(TK_F32, 4, end_in);
                MK_FLOAT64:  start_field(TK_F64, 8, end_in);
                MK_UINT8:    start_field(TK_UINT, 1, end_in);
                MK_UINT16:   start_field(TK_UINT, 2, end_in);
                MK_UINT32:   start_field(TK_UINT, 4, end_in);
                MK_UINT64:   start_field(TK_UINT, 8, end_in);
                MK_INT8:     start_field(TK_SINT, 1, end_in);
                MK_INT16:    start_field(TK_SINT, 2, end_in);
                MK_INT32:    start_field(TK_SINT, 4, end_in);
                MK_INT64:    start_field(TK_SINT, 8, end_in);
                MK_STR8:     start_field(TK_STR, 1, end_in);
                MK_STR16:    start_field(TK_STR, 2, end_in);
                MK_STR32:    start_field(TK_STR, 4, end_in);
                MK_ARRAY16:  start_field(TK_ARRAY, 2, end_in);
                MK_ARRAY32:  start_field(TK_ARRAY, 4, end_in);
                MK_MAP16:    start_field(TK_MAP, 2, end_in);
                MK_MAP32:    start_field(TK_MAP, 4, end_in);
                // Everything left in this range is an ext marker; its body is not skipped.
                default:     push_token(TK_EXT, VALUE_W'(b), 1'b0);
            endcase
        end
    endtask

    task automatic decode_byte(input logic [7:0] b, input logic end_in);
        logic [VALUE_W-1:0] v;
        token_kind_t        kind;
        if (parse_state == PS_PAYLOAD) begin
            if (owed_payload_bytes <= 1) begin
                clear_parse();
                push_token(TK_PAYLOAD, VALUE_W'(b), 1'b1);
            end else if (end_in) begin
                truncate();
            end else begin
                owed_payload_bytes = owed_payload_bytes - 32'd1;
                push_token(TK_PAYLOAD, VALUE_W'(b), 1'b0);
            end
        end else if (parse_state == PS_FIELD || parse_state == PS_SIGN_BYTE) begin
            // The first byte of a signed field fills the upper bits with its sign.
            if (parse_state == PS_SIGN_BYTE) begin
                field_acc = {VALUE_W{b[7]}};
            end
            parse_state = PS_FIELD;
            field_acc   = {field_acc[VALUE_W-9:0], b};
            if (owed_field_bytes != 0) begin
                owed_field_bytes = owed_field_bytes - 4'd1;
            end
            if (owed_field_bytes != 0) begin
                if (end_in) begin
                    truncate();
                end
            end else begin
                kind = field_kind;
                v    = field_acc;
                if (kind == TK_STR || kind == TK_BIN) begin
                    str_bin_header(kind, v[LEN_W-1:0], end_in);
                end else begin
                    clear_parse();
                    push_token(kind, v, 1'b0);
                end
            end
        end else begin
            decode_marker(b, end_in);
            if (parse_state == PS_MARKER) begin
                clear_parse();
            end
        end
    endtask

    task automatic check_token();
        token_t                 want;
        logic [KIND_W-1:0]      got_kind;
        logic [VALUE_W-1:0]     got_value;
        logic [M_PAD_W-1:0]     got_pad;
        got_kind  = m_tdata[KIND_W-1:0];
        got_value = m_tdata[KIND_W +: VALUE_W];
        got_pad   = m_tdata[M_TDATA_W-1 -: M_PAD_W];
        if (tokens_due.size() == 0) begin
            $error("token_kind: expected no token, got %0d (value %h)", got_kind, got_value);
            fails++;
        end else begin
            want = tokens_due.pop_front();
            if (got_kind !== want.kind) begin
                $error("token_kind: expected %0d, got %0d", want.kind, got_kind);
                fails++;
            end
            if (got_value !== want.value) begin
                $error("token_value: expected %h, got %h", want.value, got_value);
                fails++;
            end
            if (m_tlast !== want.last) begin
                $error("payload_last: expected %0b, got %0b", want.last, m_tlast);
                fails++;
            end
            if (got_pad !== '0) begin
                $error("m_tdata padding: expected %h, got %h", {M_PAD_W{1'b0}}, got_pad);
                fails++;
            end
        end
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            clear_parse();
            tokens_due.delete();
        end else begin
            // A token always belongs to an earlier byte, so it is checked first.
            if (m_tvalid && m_tready) begin
                check_token();
            end
            if (s_tvalid && s_tready) begin
                decode_byte(s_tdata, s_tlast);
            end
        end
        fail_count     <= fails;
        tokens_pending <= tokens_due.size();
    end

endmodule : mpk_token_checker

### tb/testbench.sv
// Top of the msgpack_token_parser_core testbench: clock, reset, byte stimulus and
// output back-pressure. Depends on mpk_pkg, mpk_marker_pkg and mpk_token_checker.
`timescale 1ns / 1ps

module testbench;
    import mpk_pkg::*;
    import mpk_marker_pkg::*;

    localparam int RANDOM_BYTES    = 1400;
    localparam int HOLD_OFF_CYCLES = 300;
    localparam int QUIET_LIMIT     = 5000;
    localparam int TAIL_CYCLES     = 10;
    localparam int SRC_GAP_PCT     = 48;
    localparam int SINK_STALL_PCT  = 48;
    localparam int BOTH_IDLE_PCT   = 38;
    localparam int MAX_PAYLOAD     = 40;

    typedef enum logic [1:0] {
        TR_STEADY,
        TR_SRC_GAPS,
        TR_SINK_STALLS,
        TR_BOTH_IDLE
    } traffic_t;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } stim_byte_t;

    logic                 aclk     = 1'b0;
    logic                 aresetn  = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [7:0]           s_tdata  = '0;
    logic                 s_tlast  = 1'b0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;
    logic                 m_tlast;
    int                   fail_count;
    int                   tokens_pending;
    traffic_t             traffic = TR_STEADY;

    stim_byte_t stim_q[$];
    logic [7:0] msg_q[$];
    int         directed_count;

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    msgpack_token_parser_core i_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    mpk_token_checker i_checker (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_tvalid       (s_tvalid),
        .s_tready       (s_tready),
        .s_tdata        (s_tdata),
        .s_tlast        (s_tlast),
        .m_tvalid       (m_tvalid),
        .m_tready       (m_tready),
        .m_tdata        (m_tdata),
        .m_tlast        (m_tlast),
        .fail_count     (fail_count),
        .tokens_pending (tokens_pending)
    );

    task automatic push_byte(input logic [7:0] d, input logic l);
        stim_q.push_back({d, l});
    endtask

    // Appends one MessagePack item to the message being built. Lengths too long to
    // send in full get at most three payload bytes and end the message there.
    task automatic add_item(output bit ends_message);
        int         sel;
        int         k;
        int         nb;
        int         i;
        logic [31:0] len;
        logic [7:0] marker;
        ends_message = 1'b0;
        sel = $urandom_range(0, 13);
        case (sel)
            0: msg_q.push_back(8'($urandom_range(0, MK_POSFIX_MAX)));
            1: msg_q.push_back(NEG_FIX_MIN | 8'($urandom_range(0, 31)));
            2: msg_q.push_back(MK_FIXMAP | 8'($urandom_range(0, 15)));
            3: msg_q.push_back(MK_FIXARRAY | 8'($urandom_range(0, 15)));
            4: begin
                case ($urandom_range(0, 3))
                    0:       msg_q.push_back(NIL_MARKER);
                    1:       msg_q.push_back(MK_FALSE);
                    2:       msg_q.push_back(MK_TRUE);
                    default: msg_q.push_back(MK_RESERVED);
                endcase
            end
            5: begin
                if ($urandom_range(0, 1) != 0) begin
                    msg_q.push_back(MK_EXT8 + 8'($urandom_range(0, 2)));
                end else begin
                    msg_q.push_back(MK_FIXEXT1 + 8'($urandom_range(0, 4)));
                end
            end
            6, 7, 8: begin
                if (sel == 8) begin
                    k      = $urandom_range(0, 1);
                    marker = MK_FLOAT32 + 8'(k);
                    nb     = 4 << k;
                end else begin
                    k      = $urandom_range(0, 3);
                    marker = ((sel == 6) ? MK_UINT8 : MK_INT8) + 8'(k);
                    nb     = 1 << k;
                end
                msg_q.push_back(marker);
                repeat (nb) msg_q.push_back(8'($urandom_range(0, 255)));
            end
            9: begin
                len = $urandom_range(0, 31);
                msg_q.push_back(MK_FIXSTR | len[7:0]);
                repeat (len) msg_q.push_back(8'($urandom_range(0, 255)));
            end
            10, 11: begin
                k      = $urandom_range(0, 2);
                marker = ((sel == 10) ? MK_STR8 : MK_BIN8) + 8'(k);
                nb     = 1 << k;
                len    = ($urandom_range(0, 4) == 0) ? $urandom : $urandom_range(0, 24);
                if (nb < 4) begin
                    len = len & ((32'd1 << (8 * nb)) - 1);
                end
                msg_q.push_back(marker);
                for (i = nb - 1; i >= 0; i--) begin
                    msg_q.push_back(len[8*i +: 8]);
                end
                if (len <= MAX_PAYLOAD) begin
                    repeat (len) msg_q.push_back(8'($urandom_range(0, 255)));
                end else begin
                    repeat ($urandom_range(0, 3)) msg_q.push_back(8'($urandom_range(0, 255)));
                    ends_message = 1'b1;
                end
            end
            default: begin
                k      = $urandom_range(0, 1);
                marker = (($urandom_range(0, 1) != 0) ? MK_ARRAY16 : MK_MAP16) + 8'(k);
                msg_q.push_back(marker);
                repeat (2 << k) msg_q.push_back(8'($urandom_range(0, 255)));
            end
        endcase
    endtask

    // Most messages are well formed; some are raw noise and some are cut short.
    task automatic add_message();
        int n_items;
        int cut;
        int i;
        bit ends;
        msg_q.delete();
        if ($urandom_range(0, 9) == 0) begin
            repeat ($urandom_range(1, 8)) msg_q.push_back(8'($urandom_range(0, 255)));
        end else begin
            n_items = $urandom_range(1, 5);
            for (i = 0; i < n_items; i++) begin
                add_item(ends);
                if (ends) break;
            end
        end
        if ($urandom_range(0, 7) == 0 && msg_q.size() > 1) begin
            cut = $urandom_range(1, msg_q.size() - 1);
            while (msg_q.size() > cut) void'(msg_q.pop_back());
        end
        for (i = 0; i < msg_q.size(); i++) begin
            push_byte(msg_q[i], i == msg_q.size() - 1);
        end
    endtask

    task automatic build_stimulus();
        // Fixint and fixmap/fixarray extremes, the single-byte markers, reserved and ext.
        push_byte(8'h00, 1'b0);
        push_byte(MK_POSFIX_MAX, 1'b0);
        push_byte(NEG_FIX_MIN, 1'b0);
        push_byte(8'hff, 1'b0);
        push_byte(MK_FIXMAP_MAX, 1'b0);
        push_byte(MK_FIXARRAY, 1'b0);
        push_byte(NIL_MARKER, 1'b0);
        push_byte(MK_FALSE, 1'b0);
        push_byte(MK_TRUE, 1'b0);
        push_byte(MK_RESERVED, 1'b0);
        push_byte(MK_FIXEXT1, 1'b0);
        // Empty str and empty bin give only a header.
        push_byte(MK_FIXSTR, 1'b0);
        push_byte(MK_BIN8, 1'b0);
        push_byte(8'h00, 1'b0);
        // Most negative int8, then a two-byte string.
        push_byte(MK_INT8, 1'b0);
        push_byte(8'h80, 1'b0);
        push_byte(MK_FIXSTR | 8'd2, 1'b0);
        push_byte(8'h41, 1'b0);
        push_byte(8'h42, 1'b0);
        // Message ends inside a field, then on a header whose payload never came.
        push_byte(MK_UINT16, 1'b0);
        push_byte(8'hff, 1'b1);
        push_byte(MK_FIXSTR | 8'd3, 1'b1);
        // An int16 that completes exactly on the last byte of a message.
        push_byte(MK_INT16, 1'b0);
        push_byte(8'hff, 1'b0);
        push_byte(8'hff, 1'b1);
        directed_count = stim_q.size();
        while (stim_q.size() < directed_count + RANDOM_BYTES) add_message();
    endtask

    // Sender: one item per handshake, with random gaps in the phases that call for them.
    initial begin
        int       idx;
        int       gap_pct;
        traffic_t mode;
        build_stimulus();
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        mode = TR_STEADY;
        for (idx = 0; idx < stim_q.size(); idx++) begin
            if (idx >= directed_count) begin
                mode = traffic_t'((idx - directed_count) * 4 / (stim_q.size() - directed_count));
            end
            traffic <= mode;
            case (mode)
                TR_SRC_GAPS:  gap_pct = SRC_GAP_PCT;
                TR_BOTH_IDLE: gap_pct = BOTH_IDLE_PCT;
                default:      gap_pct = 0;
            endcase
            while ($urandom_range(0, 99) < gap_pct) begin
                s_tvalid <= 1'b0;
                @(posedge aclk);
            end
            s_tvalid <= 1'b1;
            s_tdata  <= stim_q[idx].data;
            s_tlast  <= stim_q[idx].last;
            @(posedge aclk);
            while (!s_tready) @(posedge aclk);
        end
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (tokens_pending != 0) @(posedge aclk);
        repeat (TAIL_CYCLES) @(posedge aclk);
        if (fail_count == 0 && tokens_pending == 0) begin
            $display("[msgpack_token_parser_core] OK");
        end else begin
            $display("[msgpack_token_parser_core] ERROR");
        end
        $finish;
    end

    // Receiver: a long hold-off right after reset fills the output registers while the
    // directed items are offered, then random stalls by phase.
    initial begin
        @(posedge aclk);
        while (!aresetn) @(posedge aclk);
        repeat (HOLD_OFF_CYCLES) @(posedge aclk);
        forever begin
            case (traffic)
                TR_SINK_STALLS: m_tready <= ($urandom_range(0, 99) >= SINK_STALL_PCT);
                TR_BOTH_IDLE:   m_tready <= ($urandom_range(0, 99) >= BOTH_IDLE_PCT);
                default:        m_tready <= 1'b1;
            endcase
            @(posedge aclk);
        end
    end

    // Watchdog on cycles in which neither channel moves an item.
    initial begin
        int quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT) begin
            @(posedge aclk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
                quiet = 0;
            end else begin
                quiet++;
            end
        end
        $display("[msgpack_token_parser_core] ERROR");
        $finish;
    end

endmodule : testbench
